FILE: src/bfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types, constants and helpers for the tile box-filter downsampler.
// ----------------------------------------------------------------------------
package bfd_pkg;

	localparam int DEF_MAX_TILE_WIDTH  = 1024;
	localparam int DEF_MAX_TILE_HEIGHT = 1024;

	// width that holds any clamped tile size over the parameter range
	localparam int SIZE_W = 13;

	localparam int PIX_W     = 8;
	localparam int HSUM_W    = 11;
	localparam int CSUM_W    = 14;
	localparam int STORE_W   = 3 * CSUM_W;
	localparam int OUT_POS_W = 9;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd2;

	localparam logic [1:0]            RST_FACTOR_LOG2 = 2'd2;
	localparam logic [CFG_DATA_W-1:0] RST_TILE_WIDTH  = 11'd1024;
	localparam logic [CFG_DATA_W-1:0] RST_TILE_HEIGHT = 11'd1024;

	// per-beat decisions taken at the input
	typedef struct packed {
		logic block_end;
		logic last_row;
		logic use_store;
		logic done;
	} bfd_step_t;

	// clamp, round down to the factor, raise to at least the factor
	function automatic logic [SIZE_W-1:0] effective_size(
		input logic [CFG_DATA_W-1:0] size_reg,
		input logic [SIZE_W-1:0]     limit,
		input logic [1:0]            k
	);
		logic [SIZE_W-1:0] v;
		logic [SIZE_W-1:0] f;
		v = SIZE_W'(size_reg);
		f = SIZE_W'(1) << k;
		if (v > limit) begin
			v = limit;
		end
		v = v & ~(f - SIZE_W'(1));
		if (v < f) begin
			v = f;
		end
		return v;
	endfunction

endpackage

FILE: src/box_filter_tile_downsample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_tile_downsample
// Per-channel box-filter averaging of a raster tile by a factor of 2, 4 or 8.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per cycle in raster order and emits the floor average of
// every factor-by-factor block, with its column and row in the reduced tile;
// tlast marks the last block of the tile. A beat is taken every cycle while
// the output side keeps up; a block result passes the sum stage and the result
// register before it appears on m_tvalid. The column-sum line store is read
// when a pixel enters the sum stage and written when a block-end pixel leaves
// it. The line store comes up with unknown contents and needs no clearing:
// the first row of every band overwrites it. The user must write factor and
// tile size through the config port between tiles; the block does not check.
module box_filter_tile_downsample #(
	parameter int MAX_TILE_WIDTH  = bfd_pkg::DEF_MAX_TILE_WIDTH,
	parameter int MAX_TILE_HEIGHT = bfd_pkg::DEF_MAX_TILE_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bfd_pkg::IN_DATA_W-1:0]   s_tdata,  // red_in, green_in, blue_in
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// red_out, green_out, blue_out, out_column, out_row, zero pad
	output logic [bfd_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tlast,  // tile_done
	input  logic                            cfg_we,
	input  logic [bfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bfd_pkg::*;

	localparam int DEPTH  = MAX_TILE_WIDTH / 2;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int BAND_W = $clog2(MAX_TILE_HEIGHT / 2);

	logic [1:0]            factor_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;

	bfd_step_t         step;
	logic [IDX_W-1:0]  idx;
	logic [BAND_W-1:0] band;
	logic [1:0]        k;

	logic [HSUM_W-1:0] hsum_q  [3];
	logic [HSUM_W-1:0] hs_next [3];

	logic              s1_valid_q;
	bfd_step_t         step_s1;
	logic [HSUM_W-1:0] hs_s1 [3];
	logic [IDX_W-1:0]  idx_s1;
	logic [BAND_W-1:0] band_s1;
	logic [1:0]        k_s1;
	logic [STORE_W-1:0] rd_s1;

	logic [STORE_W-1:0] store_mem [DEPTH];

	logic [CSUM_W-1:0]  sum [3];
	logic [STORE_W-1:0] wdata;
	logic [PIX_W-1:0]   avg [3];
	logic               emits;
	logic               out_free;
	logic               s1_free;
	logic               accept;
	logic               mem_we;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= RST_FACTOR_LOG2;
			width_q  <= RST_TILE_WIDTH;
			height_q <= RST_TILE_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FACTOR_LOG2: factor_q <= cfg_data[1:0];
				CFG_TILE_WIDTH:  width_q  <= cfg_data;
				CFG_TILE_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bfd_pos #(
		.MAX_TILE_WIDTH  (MAX_TILE_WIDTH),
		.MAX_TILE_HEIGHT (MAX_TILE_HEIGHT),
		.IDX_W           (IDX_W),
		.BAND_W          (BAND_W)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.factor_log2 (factor_q),
		.tile_width  (width_q),
		.tile_height (height_q),
		.step        (step),
		.idx         (idx),
		.band        (band),
		.k_eff       (k)
	);

	// handshake
	always_comb begin
		emits    = step_s1.block_end && step_s1.last_row;
		out_free = !out_valid_q || m_tready;
		s1_free  = !s1_valid_q || !emits || out_free;
		accept   = s_tvalid && s1_free;
		mem_we   = s1_valid_q && s1_free && step_s1.block_end;
	end

	assign s_tready = s1_free;

	// horizontal running sums of the open block row
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			hs_next[c] = hsum_q[c] + HSUM_W'(s_tdata[c*PIX_W +: PIX_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				hsum_q[c] <= '0;
			end
		end else if (accept) begin
			for (int c = 0; c < 3; c++) begin
				hsum_q[c] <= step.block_end ? '0 : hs_next[c];
			end
		end
	end

	// sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_free) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
			idx_s1  <= idx;
			band_s1 <= band;
			k_s1    <= k;
			for (int c = 0; c < 3; c++) begin
				hs_s1[c] <= hs_next[c];
			end
		end
	end

	// column-sum line store, read on entry and written on exit of the sum stage
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[idx_s1] <= wdata;
		end
		if (accept) begin
			rd_s1 <= store_mem[idx];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = CSUM_W'(hs_s1[c])
				+ (step_s1.use_store ? rd_s1[c*CSUM_W +: CSUM_W] : CSUM_W'(0));
			avg[c] = PIX_W'(sum[c] >> {k_s1, 1'b0});
		end
		wdata = {sum[2], sum[1], sum[0]};
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q && emits;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q && emits) begin
			out_data_q <= {6'd0, OUT_POS_W'(band_s1), OUT_POS_W'(idx_s1),
				avg[2], avg[1], avg[0]};
			out_last_q <= step_s1.done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: src/bfd_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_pos
// Column, row-in-band and band counters with the per-beat block decisions.
// ----------------------------------------------------------------------------
module bfd_pos #(
	parameter int MAX_TILE_WIDTH  = bfd_pkg::DEF_MAX_TILE_WIDTH,
	parameter int MAX_TILE_HEIGHT = bfd_pkg::DEF_MAX_TILE_HEIGHT,
	parameter int IDX_W           = $clog2(MAX_TILE_WIDTH / 2),
	parameter int BAND_W          = $clog2(MAX_TILE_HEIGHT / 2)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [1:0]                        factor_log2,
	input  logic [bfd_pkg::CFG_DATA_W-1:0]    tile_width,
	input  logic [bfd_pkg::CFG_DATA_W-1:0]    tile_height,
	output bfd_pkg::bfd_step_t                step,
	output logic [IDX_W-1:0]                  idx,
	output logic [BAND_W-1:0]                 band,
	output logic [1:0]                        k_eff
);
	import bfd_pkg::*;

	localparam int COL_W = $clog2(MAX_TILE_WIDTH);
	localparam int LW    = SIZE_W + 3;

	logic [COL_W-1:0]  col_q;
	logic [2:0]        row_q;
	logic [BAND_W-1:0] band_q;

	logic [1:0]        k;
	logic [3:0]        f;
	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic [COL_W-1:0]  col_mask;
	logic              last_col;
	logic              last_row;
	logic              last_band;

	always_comb begin
		k        = (factor_log2 == 2'd0) ? 2'd1 : factor_log2;
		f        = 4'd1 << k;
		w_eff    = effective_size(tile_width, SIZE_W'(MAX_TILE_WIDTH), k);
		h_eff    = effective_size(tile_height, SIZE_W'(MAX_TILE_HEIGHT), k);
		col_mask = COL_W'(f - 4'd1);
		last_col = (SIZE_W'(col_q) + SIZE_W'(1)) >= w_eff;
		last_row = row_q >= 3'(f - 4'd1);
		last_band = ((LW'(band_q) + LW'(1)) << k) >= LW'(h_eff);

		step.block_end = ((col_q & col_mask) == col_mask) || last_col;
		step.last_row  = last_row;
		step.use_store = row_q != 3'd0;
		step.done      = last_col && last_band && last_row;
		idx            = IDX_W'(col_q >> k);
		band           = band_q;
		k_eff          = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			band_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					band_q <= last_band ? '0 : band_q + BAND_W'(1);
				end else begin
					row_q <= row_q + 3'd1;
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

FILE: src/bfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_checker
// Port-level checks for the tile downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module bfd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bfd_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                            m_tlast
);
	import bfd_pkg::*;

	// stalled result beat stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result beat changed");

	// with the result register empty the input side never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while result register empty");

	// a fresh result traces back to an accepted input beat through the sum stage and the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result appeared without a matching input beat");

	// no result beat in the cycle after reset was held
	assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind box_filter_tile_downsample bfd_checker u_bfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
